// ===== hdl/eqtl_pkg.sv =====
// Shared types and constants of the escaped quoted token lexer.
// No dependencies; every other file of the block imports this package.
package eqtl_pkg;

   // Result kinds.
   localparam logic [1:0] K_DATA = 2'd0;
   localparam logic [1:0] K_EOD  = 2'd1;
   localparam logic [1:0] K_EOL  = 2'd2;
   localparam logic [1:0] K_EOF  = 2'd3;

   // Depth of the queue between front and back.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef enum logic [3:0] {
      LEX_IWS   = 4'd0,
      LEX_PLAIN = 4'd1,
      LEX_QUOT  = 4'd2,
      LEX_BSP   = 4'd3,
      LEX_BSQ   = 4'd4,
      LEX_SPP   = 4'd5,
      LEX_SPQ   = 4'd6,
      LEX_CMT   = 4'd7
   } lex_state_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_char;
      logic       last;
   } rsp_type;

   // Everything one input item causes: one or two results.
   typedef struct packed {
      logic    two;
      rsp_type res0;
      rsp_type res1;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== hdl/eqtl_front.sv =====
// Front of the lexer: accepts items, runs the lexer state machine and
// packs the results of each item into one queue entry. Uses eqtl_pkg.
module eqtl_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  eqtl_pkg::req_type     req_data,
   input  eqtl_pkg::q_status_type q_status,
   output logic                  push,
   output eqtl_pkg::entry_type   push_entry
);
   import eqtl_pkg::*;

   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_T      = 8'h74;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   lex_state_type state_ff, state_in;
   logic [1:0]    n;
   logic [1:0]    k0, k1;
   logic [7:0]    c0;
   logic [7:0]    ch;
   logic          accept;
   logic          ch_ws;
   logic          esc_drop;
   logic [7:0]    esc_char;

   assign ch        = req_data.in_byte;
   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign ch_ws     = is_ws(ch);
   assign esc_drop  = is_letter(ch) && (ch != CH_N) && (ch != CH_T);
   assign esc_char  = (ch == CH_N) ? CH_NL : ((ch == CH_T) ? CH_TAB : ch);

   always_comb begin
      n        = 2'd0;
      k0       = K_DATA;
      c0       = ch;
      k1       = K_EOF;
      state_in = state_ff;
      if (req_data.is_end) begin
         state_in = LEX_IWS;
         unique case (state_ff) inside
            LEX_CMT: begin
               n  = 2'd2;
               k0 = K_EOL;
            end
            LEX_PLAIN, LEX_QUOT, LEX_BSP, LEX_BSQ, LEX_SPP, LEX_SPQ: begin
               n  = 2'd2;
               k0 = K_EOD;
            end
            default: begin
               n  = 2'd1;
               k0 = K_EOF;
            end
         endcase
      end else begin
         unique case (state_ff) inside
            LEX_CMT: begin
               if (ch == CH_NL) begin
                  n        = 2'd1;
                  k0       = K_EOL;
                  state_in = LEX_IWS;
               end
            end
            LEX_PLAIN: begin
               if (ch == CH_BSLASH) begin
                  state_in = LEX_BSP;
               end else if (ch == CH_HASH) begin
                  n        = 2'd1;
                  k0       = K_EOD;
                  state_in = LEX_CMT;
               end else if (ch == CH_QUOTE) begin
                  state_in = LEX_QUOT;
               end else if (ch == CH_NL) begin
                  n        = 2'd2;
                  k0       = K_EOD;
                  k1       = K_EOL;
                  state_in = LEX_IWS;
               end else if (ch_ws) begin
                  n        = 2'd1;
                  k0       = K_EOD;
                  state_in = LEX_IWS;
               end else begin
                  n = 2'd1;
               end
            end
            LEX_QUOT: begin
               if (ch == CH_BSLASH) begin
                  state_in = LEX_BSQ;
               end else if (ch == CH_QUOTE) begin
                  state_in = LEX_PLAIN;
               end else if (ch == CH_NL) begin
                  n        = 2'd2;
                  k0       = K_EOD;
                  k1       = K_EOL;
                  state_in = LEX_IWS;
               end else begin
                  n = 2'd1;
               end
            end
            LEX_BSP, LEX_BSQ: begin
               if (ch_ws) begin
                  state_in = (state_ff == LEX_BSP) ? LEX_SPP : LEX_SPQ;
               end else begin
                  if (!esc_drop) begin
                     n  = 2'd1;
                     c0 = esc_char;
                  end
                  state_in = (state_ff == LEX_BSP) ? LEX_PLAIN : LEX_QUOT;
               end
            end
            LEX_SPP: begin
               if (ch_ws) begin
                  state_in = LEX_SPP;
               end else if (ch == CH_BSLASH) begin
                  state_in = LEX_BSP;
               end else if (ch == CH_HASH) begin
                  n        = 2'd1;
                  k0       = K_EOD;
                  state_in = LEX_CMT;
               end else if (ch == CH_QUOTE) begin
                  state_in = LEX_QUOT;
               end else begin
                  n        = 2'd1;
                  state_in = LEX_PLAIN;
               end
            end
            LEX_SPQ: begin
               if (ch_ws) begin
                  state_in = LEX_SPQ;
               end else if (ch == CH_BSLASH) begin
                  state_in = LEX_BSQ;
               end else if (ch == CH_QUOTE) begin
                  state_in = LEX_PLAIN;
               end else begin
                  n        = 2'd1;
                  state_in = LEX_QUOT;
               end
            end
            default: begin
               // Initial whitespace; unused codes behave the same way.
               if (ch == CH_NL) begin
                  n  = 2'd1;
                  k0 = K_EOL;
               end else if (ch_ws) begin
                  state_in = LEX_IWS;
               end else if (ch == CH_BSLASH) begin
                  state_in = LEX_BSP;
               end else if (ch == CH_HASH) begin
                  state_in = LEX_CMT;
               end else if (ch == CH_QUOTE) begin
                  state_in = LEX_QUOT;
               end else begin
                  n        = 2'd1;
                  state_in = LEX_PLAIN;
               end
            end
         endcase
      end
   end

   always_comb begin
      push_entry.two           = (n == 2'd2);
      push_entry.res0.kind     = k0;
      push_entry.res0.out_char = (k0 == K_DATA) ? c0 : 8'd0;
      push_entry.res0.last     = (n == 2'd1);
      push_entry.res1.kind     = k1;
      push_entry.res1.out_char = 8'd0;
      push_entry.res1.last     = 1'b1;
   end

   assign push = accept && (n != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LEX_IWS;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/eqtl_queue.sv =====
// Short queue of result entries between the lexer front and back.
// Uses eqtl_pkg for the entry type and depth.
module eqtl_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  eqtl_pkg::entry_type    push_entry,
   input  logic                   pop,
   output eqtl_pkg::entry_type    head_entry,
   output eqtl_pkg::q_status_type q_status
);
   import eqtl_pkg::*;

   entry_type         entries_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;

   assign head_entry     = entries_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QDEPTH[QPTR_W:0]);
   assign q_status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue read while empty");

endmodule

// ===== hdl/eqtl_back.sv =====
// Back of the lexer: takes queue entries and hands out their results one
// per cycle while rsp_ready is high, from an output register. Uses eqtl_pkg.
module eqtl_back (
   input  logic                   clock,
   input  logic                   reset,
   input  eqtl_pkg::entry_type    head_entry,
   input  eqtl_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output eqtl_pkg::rsp_type      rsp_data
);
   import eqtl_pkg::*;

   logic      hold_ff, hold_in;
   logic      sel_ff, sel_in;
   entry_type entry_ff, entry_in;
   logic      advance;
   logic      load;

   // A taken first result of a two-result entry moves on to the second one;
   // otherwise a taken result, or an empty register, loads the next entry.
   assign advance = hold_ff && rsp_ready && !sel_ff && entry_ff.two;
   assign load    = !hold_ff || (rsp_ready && !advance);
   assign pop     = load && !q_status.empty;

   always_comb begin
      hold_in  = hold_ff;
      sel_in   = sel_ff;
      entry_in = entry_ff;
      if (advance) begin
         sel_in = 1'b1;
      end else if (load) begin
         hold_in  = !q_status.empty;
         sel_in   = 1'b0;
         entry_in = head_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         sel_ff  <= 1'b0;
      end else begin
         hold_ff <= hold_in;
         sel_ff  <= sel_in;
      end
   end

   assign rsp_valid = hold_ff;
   assign rsp_data  = sel_ff ? entry_ff.res1 : entry_ff.res0;

   a_second_only_if_two: assert property (@(posedge clock) disable iff (reset)
      (hold_ff && sel_ff) |-> entry_ff.two)
      else $error("second result shown for a one-result entry");

   a_last_ends_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last) |=> (rsp_valid && sel_ff))
      else $error("entry left before its last result");

endmodule

// ===== hdl/escaped_quoted_token_lexer_core.sv =====
// Streaming lexer: one byte or end-of-input mark per item in, data
// characters and end-of-data, end-of-line and end-of-file marks out.
// Uses eqtl_pkg, eqtl_front, eqtl_queue and eqtl_back.
//
// An item is taken every cycle while the four-entry result queue has room;
// the lexer state machine in the front decides each item combinationally in
// the cycle it is taken, so the input rate is one item per cycle while the
// queue has room. Each item yields zero, one or two results, and the output
// register delivers one result per cycle while rsp_ready is high, so items
// that give two results (a token closed by a newline, or end of input inside
// a token or comment) hand them out one after the other and can fill the
// queue and briefly hold off the input. An accepted item's results pass
// through a queue entry and then the output register in the back before
// they are offered on rsp; last marks the final result of each item.
module escaped_quoted_token_lexer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  eqtl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output eqtl_pkg::rsp_type rsp_data
);
   import eqtl_pkg::*;

   q_status_type q_status;
   entry_type    push_entry;
   entry_type    head_entry;
   logic         push;
   logic         pop;

   eqtl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   eqtl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   eqtl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
